FILE: rtl/hex_record_framer_crc16_defines.svh
// Assertion macros for the hex record framer.
// Used by files that carry concurrent checks; they expect clk and rst_n in scope.
`ifndef HEX_RECORD_FRAMER_CRC16_DEFINES_SVH
`define HEX_RECORD_FRAMER_CRC16_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define HRF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define HRF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define HRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hrf_pkg.sv
// Shared types, constants and functions of the hex record framer.
// No dependencies; used by hrf_text and hex_record_framer_crc16.
package hrf_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] CHAR_DATA_HEAD = 8'h44;  // 'D'
    localparam logic [7:0] CHAR_END_HEAD  = 8'h45;  // 'E'
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    // Character positions within the text of one transaction
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_HEAD      = 5'd0;
    localparam logic [POS_W-1:0] POS_DATA      = 5'd13;  // first digit of the data byte
    localparam logic [POS_W-1:0] POS_DATA_LAST = 5'd14;  // record stays open
    localparam logic [POS_W-1:0] POS_REC_NL    = 5'd19;  // record closes
    localparam logic [POS_W-1:0] POS_END_NL    = 5'd9;   // end record newline

    localparam int DIGIT_COUNT = 18;
    localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);

    typedef struct packed {
        logic        kind;
        logic [23:0] start_address;
        logic [5:0]  record_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } text_t;

    // Fields that one transaction prints
    typedef struct packed {
        logic        is_end;
        logic [15:0] seq;
        logic [23:0] addr;
        logic [7:0]  len;
        logic [7:0]  data;
        logic [15:0] crc;
    } rec_fields_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  value);
        logic [15:0] c;
        c = crc_in ^ {value, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_header(input logic [15:0] crc_in,
                                                 input logic [15:0] seq,
                                                 input logic [23:0] addr,
                                                 input logic [7:0]  len);
        logic [15:0] c;
        c = crc16_byte(crc_in, seq[15:8]);
        c = crc16_byte(c, seq[7:0]);
        c = crc16_byte(c, addr[23:16]);
        c = crc16_byte(c, addr[15:8]);
        c = crc16_byte(c, addr[7:0]);
        c = crc16_byte(c, len);
        return c;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
    endfunction

endpackage

FILE: rtl/hrf_text.sv
// Character generator: picks the ASCII character at one position of a record.
// Depends on hrf_pkg.
module hrf_text (
    input  hrf_pkg::rec_fields_t           fields,
    input  logic [hrf_pkg::POS_W-1:0]      pos,
    output logic [7:0]                     character
);

    logic [4*hrf_pkg::DIGIT_COUNT-1:0] digits;
    logic [3:0]                        nib_arr [hrf_pkg::DIGIT_COUNT];
    logic [hrf_pkg::POS_W-1:0]         digit_pos;
    logic [hrf_pkg::DIGIT_IDX_W-1:0]   digit_idx;
    logic [hrf_pkg::POS_W-1:0]         nl_pos;

    always_comb
    begin
        if (fields.is_end)
        begin
            digits = {fields.seq, fields.crc, 40'h0};
        end
        else
        begin
            digits = {fields.seq, fields.addr, fields.len, fields.data, fields.crc};
        end
    end

    for (genvar i = 0; i < hrf_pkg::DIGIT_COUNT; i++)
    begin : g_nib
        assign nib_arr[i] = digits[4*(hrf_pkg::DIGIT_COUNT-1-i) +: 4];
    end

    // Digits start right after the head letter; clamp keeps the index in range
    assign digit_pos = pos - 5'd1;
    assign digit_idx = (digit_pos < hrf_pkg::POS_W'(hrf_pkg::DIGIT_COUNT))
                     ? digit_pos[hrf_pkg::DIGIT_IDX_W-1:0] : '0;
    assign nl_pos    = fields.is_end ? hrf_pkg::POS_END_NL : hrf_pkg::POS_REC_NL;

    always_comb
    begin
        case (pos)
            hrf_pkg::POS_HEAD:
            begin
                character = fields.is_end ? hrf_pkg::CHAR_END_HEAD : hrf_pkg::CHAR_DATA_HEAD;
            end
            default:
            begin
                if (pos == nl_pos)
                begin
                    character = hrf_pkg::CHAR_NEWLINE;
                end
                else
                begin
                    character = hrf_pkg::hex_ascii(nib_arr[digit_idx]);
                end
            end
        endcase
    end

endmodule

FILE: rtl/hex_record_framer_crc16.sv
// Hex record framer: turns data bytes into ASCII 'D' records with CRC-16 and emits an 'E'
// end record with the stream CRC. Depends on hrf_pkg, hrf_text and the defines header.
//
// The text leaves one character per cycle while text_ready is high. An item has 2
// characters for a byte inside a record, 7 for the byte that closes a record, 15 for the
// byte that opens one (20 if it also closes it) and 10 for a finish item. The output port
// is the only limit; the input is registered and the whole update of sequence, record CRC
// and stream CRC for an item happens in the cycle it enters the character serializer, so
// items follow each other without gaps. A taken item passes the input register and the
// serializer before its text reaches the output register. record_length 0 counts as 1,
// values above MAX_BYTES are cut to MAX_BYTES; a finish item drops any open record.
`include "hex_record_framer_crc16_defines.svh"

module hex_record_framer_crc16 #(
    parameter int MAX_BYTES = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  hrf_pkg::item_t item,
    output logic           text_valid,
    input  logic           text_ready,
    output hrf_pkg::text_t text
);

    localparam logic [7:0] MaxLen = 8'(MAX_BYTES);

    // Input register
    logic           in_valid_reg;
    hrf_pkg::item_t in_item_reg;

    // Framer state
    logic [15:0] seq_reg,    seq_next;
    logic [15:0] rec_crc_reg, rec_crc_next;
    logic [15:0] stream_reg, stream_next;
    logic [15:0] pend_reg,   pend_next;
    logic [5:0]  bpos_reg,   bpos_next;
    logic [5:0]  total_reg,  total_next;

    // Serializer (result register)
    logic                         ser_valid_reg;
    hrf_pkg::rec_fields_t         ser_fields_reg, ser_fields_next;
    logic [hrf_pkg::POS_W-1:0]    ser_pos_reg, ser_start_next;
    logic [hrf_pkg::POS_W-1:0]    ser_stop_reg, ser_stop_next;

    // Output register
    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic        out_last_reg;

    logic        advance;
    logic        ser_at_stop;
    logic        ser_load;
    logic [7:0]  ser_char;

    // Item processing
    logic        open_rec;
    logic [5:0]  len_eff;
    logic [15:0] rc_base, pd_base, rc_data, pd_data;
    logic [5:0]  tot_eff, bpos_inc;
    logic        close_rec;

    assign advance     = ser_valid_reg && (!out_valid_reg || text_ready);
    assign ser_at_stop = (ser_pos_reg == ser_stop_reg);
    assign ser_load    = in_valid_reg && (!ser_valid_reg || (advance && ser_at_stop));
    assign item_ready  = !in_valid_reg || ser_load;

    always_comb
    begin
        open_rec = (bpos_reg == 6'd0);
        len_eff  = (in_item_reg.record_length == 6'd0) ? 6'd1 : in_item_reg.record_length;
        if ({2'b00, len_eff} > MaxLen)
        begin
            len_eff = MaxLen[5:0];
        end

        if (open_rec)
        begin
            rc_base = hrf_pkg::crc16_header(hrf_pkg::CRC_INIT, seq_reg,
                                            in_item_reg.start_address, {2'b00, len_eff});
            pd_base = hrf_pkg::crc16_header(stream_reg, seq_reg,
                                            in_item_reg.start_address, {2'b00, len_eff});
            tot_eff = len_eff;
        end
        else
        begin
            rc_base = rec_crc_reg;
            pd_base = pend_reg;
            tot_eff = total_reg;
        end
        rc_data   = hrf_pkg::crc16_byte(rc_base, in_item_reg.data_byte);
        pd_data   = hrf_pkg::crc16_byte(pd_base, in_item_reg.data_byte);
        bpos_inc  = bpos_reg + 6'd1;
        close_rec = (bpos_inc >= tot_eff);

        seq_next     = seq_reg;
        rec_crc_next = rec_crc_reg;
        stream_next  = stream_reg;
        pend_next    = pend_reg;
        bpos_next    = bpos_reg;
        total_next   = total_reg;

        ser_fields_next.is_end = in_item_reg.kind;
        ser_fields_next.seq    = seq_reg;
        ser_fields_next.addr   = in_item_reg.start_address;
        ser_fields_next.len    = {2'b00, len_eff};
        ser_fields_next.data   = in_item_reg.data_byte;

        if (in_item_reg.kind)
        begin
            ser_fields_next.crc = stream_reg;
            ser_start_next      = hrf_pkg::POS_HEAD;
            ser_stop_next       = hrf_pkg::POS_END_NL;
            seq_next            = 16'h0000;
            rec_crc_next        = hrf_pkg::CRC_INIT;
            stream_next         = hrf_pkg::CRC_INIT;
            pend_next           = hrf_pkg::CRC_INIT;
            bpos_next           = 6'd0;
            total_next          = 6'd0;
        end
        else
        begin
            ser_fields_next.crc = rc_data;
            ser_start_next      = open_rec ? hrf_pkg::POS_HEAD : hrf_pkg::POS_DATA;
            ser_stop_next       = close_rec ? hrf_pkg::POS_REC_NL : hrf_pkg::POS_DATA_LAST;
            rec_crc_next        = rc_data;
            pend_next           = pd_data;
            total_next          = tot_eff;
            if (close_rec)
            begin
                stream_next = pd_data;
                seq_next    = seq_reg + 16'd1;
                bpos_next   = 6'd0;
            end
            else
            begin
                bpos_next = bpos_inc;
            end
        end
    end

    hrf_text u_text (
        .fields    (ser_fields_reg),
        .pos       (ser_pos_reg),
        .character (ser_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= 16'h0000;
            rec_crc_reg <= hrf_pkg::CRC_INIT;
            stream_reg  <= hrf_pkg::CRC_INIT;
            pend_reg    <= hrf_pkg::CRC_INIT;
            bpos_reg    <= 6'd0;
            total_reg   <= 6'd0;
        end
        else if (ser_load)
        begin
            seq_reg     <= seq_next;
            rec_crc_reg <= rec_crc_next;
            stream_reg  <= stream_next;
            pend_reg    <= pend_next;
            bpos_reg    <= bpos_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_pos_reg   <= hrf_pkg::POS_HEAD;
            ser_stop_reg  <= hrf_pkg::POS_HEAD;
        end
        else if (ser_load)
        begin
            ser_valid_reg <= 1'b1;
            ser_pos_reg   <= ser_start_next;
            ser_stop_reg  <= ser_stop_next;
        end
        else if (advance)
        begin
            // drop the transaction after its last character, otherwise step on
            if (ser_at_stop)
            begin
                ser_valid_reg <= 1'b0;
            end
            else
            begin
                ser_pos_reg <= ser_pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_fields_reg <= ser_fields_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (text_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_char_reg <= ser_char;
            out_last_reg <= ser_at_stop;
        end
    end

    assign text_valid     = out_valid_reg;
    assign text.character = out_char_reg;
    assign text.last_char = out_last_reg;

    `HRF_ASSERT_IMPLIES(a_ser_pos_range, ser_valid_reg, ser_pos_reg <= ser_stop_reg,
        "serializer position ran past its stop")
    `HRF_ASSERT_ALWAYS(a_bpos_in_record, (bpos_reg == 6'd0) || (bpos_reg < total_reg),
        "byte position outside open record")
    `HRF_ASSERT_IMPLIES(a_load_when_free, ser_load, !ser_valid_reg || (advance && ser_at_stop),
        "serializer reloaded while busy")
    `HRF_ASSERT_NEXT(a_accept_held, item_valid && item_ready, in_valid_reg,
        "accepted transaction not held in input register")

endmodule

FILE: tb/hrf_checker.sv
`timescale 1ns / 1ps
// Checker for the hex record framer: watches both channels, predicts the record text
// and compares it character by character. Depends on hrf_pkg for the payload types.
module hrf_checker #(
    parameter int MAX_BYTES = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic           item_ready,
    input  hrf_pkg::item_t item,
    input  logic           text_valid,
    input  logic           text_ready,
    input  hrf_pkg::text_t text,
    output int             fail_count,
    output int             pending
);

    logic [15:0]    seq_no;
    logic [15:0]    rec_crc;
    logic [15:0]    image_crc;
    logic [15:0]    stream_run;
    int             byte_pos;
    int             rec_len;
    int             fail_total;
    logic [7:0]     line_chars[$];
    hrf_pkg::text_t expected_text[$];

    // Bit-serial form of the CCITT update, MSB first
    function automatic logic [15:0] crc_ccitt_update(input logic [15:0] crc,
                                                     input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ hrf_pkg::CRC_POLY;
        end
        return c;
    endfunction

    task automatic absorb(input logic [7:0] b);
        rec_crc    = crc_ccitt_update(rec_crc, b);
        stream_run = crc_ccitt_update(stream_run, b);
    endtask

    task automatic put_hex(input logic [23:0] value, input int digits);
        logic [7:0] nib;
        for (int d = digits - 1; d >= 0; d--)
        begin
            nib = 8'((value >> (4 * d)) & 24'hF);
            line_chars.push_back(nib < 8'd10 ? 8'h30 + nib : 8'h41 + nib - 8'd10);
        end
    endtask

    task automatic clear_stream();
        seq_no     = '0;
        rec_crc    = hrf_pkg::CRC_INIT;
        image_crc  = hrf_pkg::CRC_INIT;
        stream_run = hrf_pkg::CRC_INIT;
        byte_pos   = 0;
        rec_len    = 0;
    endtask

    task automatic frame_item(input hrf_pkg::item_t it);
        int             len;
        int             n;
        hrf_pkg::text_t t;
        if (it.kind)
        begin
            line_chars.push_back(hrf_pkg::CHAR_END_HEAD);
            put_hex({8'h00, seq_no}, 4);
            put_hex({8'h00, image_crc}, 4);
            line_chars.push_back(hrf_pkg::CHAR_NEWLINE);
            // drop any open record along with the stream
            clear_stream();
        end
        else
        begin
            if (byte_pos == 0)
            begin
                len = it.record_length;
                if (len == 0)
                    len = 1;
                if (len > MAX_BYTES)
                    len = MAX_BYTES;
                rec_len    = len;
                rec_crc    = hrf_pkg::CRC_INIT;
                stream_run = image_crc;
                absorb(seq_no[15:8]);
                absorb(seq_no[7:0]);
                absorb(it.start_address[23:16]);
                absorb(it.start_address[15:8]);
                absorb(it.start_address[7:0]);
                absorb(8'(len));
                line_chars.push_back(hrf_pkg::CHAR_DATA_HEAD);
                put_hex({8'h00, seq_no}, 4);
                put_hex(it.start_address, 6);
                put_hex(24'(len), 2);
            end
            absorb(it.data_byte);
            put_hex({16'h0000, it.data_byte}, 2);
            byte_pos++;
            if (byte_pos >= rec_len)
            begin
                put_hex({8'h00, rec_crc}, 4);
                line_chars.push_back(hrf_pkg::CHAR_NEWLINE);
                image_crc  = stream_run;
                seq_no     = seq_no + 16'd1;
                byte_pos   = 0;
            end
        end
        n = line_chars.size();
        for (int i = 0; i < n; i++)
        begin
            t.character = line_chars[i];
            t.last_char = (i == n - 1);
            expected_text.push_back(t);
        end
        line_chars.delete();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hrf_pkg::text_t want;
        if (!rst_n)
        begin
            clear_stream();
            expected_text.delete();
            line_chars.delete();
            fail_total = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                frame_item(item);
            if (text_valid && text_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: unexpected character %02h last %0d", $realtime,
                                 text.character, text.last_char);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text.character !== want.character || text.last_char !== want.last_char)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: text mismatch: expected %02h last %0d, got %02h last %0d",
                                     $realtime, want.character, want.last_char,
                                     text.character, text.last_char);
                    end
                end
            end
            fail_count <= fail_total;
            pending    <= expected_text.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the hex record framer testbench: clock, reset, stimulus and verdict.
// Depends on hrf_pkg, hex_record_framer_crc16 and hrf_checker.
module tb_top;

    localparam int MAX_BYTES    = 32;
    localparam int RANDOM_ITEMS = 160;
    localparam int CALM_AFTER   = 125;

    logic           clk;
    logic           rst_n;
    logic           item_valid;
    logic           item_ready;
    hrf_pkg::item_t item;
    logic           text_valid;
    logic           text_ready;
    hrf_pkg::text_t text;
    int             fail_count;
    int             pending;
    int             random_sent;
    bit             calm;

    hex_record_framer_crc16 #(
        .MAX_BYTES(MAX_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .text_valid(text_valid),
        .text_ready(text_ready),
        .text      (text)
    );

    hrf_checker #(
        .MAX_BYTES(MAX_BYTES)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .text_valid(text_valid),
        .text_ready(text_ready),
        .text      (text),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one transaction, with an optional idle burst in front of it
    task automatic send_item(input logic k, input logic [23:0] a, input logic [5:0] l,
                             input logic [7:0] d);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{k, a, l, d};
        do @(posedge clk); while (!item_ready);
    endtask

    // Drop valid after the last transaction, then wait for all text to come out
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_block(input logic [23:0] a, input logic [5:0] l, input int count);
        for (int b = 0; b < count; b++)
        begin
            if (b == 0)
                send_item(1'b0, a, l, 8'($urandom));
            else
                send_item(1'b0, 24'($urandom), 6'($urandom), 8'($urandom));
            random_sent++;
        end
    endtask

    // Receiver: stall in bursts, never once the run goes calm
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 13);
                text_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                text_ready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("** hex_record_framer_crc16: FAILED **");
        $finish;
    end

    initial
    begin
        int r;
        int len_field;
        int eff;
        int take;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        text_ready  = 1'b0;
        calm        = 1'b0;
        random_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single-byte records at the field extremes, zero length taken as one
        send_item(1'b0, 24'h000000, 6'd1, 8'h00);
        send_item(1'b0, 24'hFFFFFF, 6'd0, 8'hFF);
        // Later fields of a record are ignored
        send_item(1'b0, 24'h123456, 6'd3, 8'hA5);
        send_item(1'b0, 24'hFFFFFF, 6'd63, 8'h5A);
        send_item(1'b0, 24'h000000, 6'd0, 8'h0F);
        send_item(1'b1, 24'hFFFFFF, 6'd63, 8'hFF);
        // Finish with nothing open
        send_item(1'b1, 24'h000000, 6'd0, 8'h00);
        // Finish drops a partial record
        send_item(1'b0, 24'hABCDEF, 6'd4, 8'h80);
        send_item(1'b0, 24'h000001, 6'd1, 8'h01);
        send_item(1'b1, 24'h000000, 6'd0, 8'h00);
        send_item(1'b0, 24'h800000, 6'd2, 8'h7F);
        send_item(1'b0, 24'h7FFFFF, 6'd2, 8'hFE);
        send_item(1'b1, 24'h555555, 6'd42, 8'hAA);

        // Hold off until the framer has flushed everything
        drain();

        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent >= CALM_AFTER)
                calm = 1'b1;
            if (random_sent > RANDOM_ITEMS / 2 && random_sent < RANDOM_ITEMS / 2 + 4)
                drain();
            r = $urandom_range(0, 19);
            if (r < 2)
            begin
                send_item(1'b1, 24'($urandom), 6'($urandom), 8'($urandom));
                random_sent++;
            end
            else
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    len_field = 0;
                else if (r == 1)
                    len_field = 32;
                else if (r == 2)
                    len_field = $urandom_range(33, 63);
                else if (r < 6)
                    len_field = $urandom_range(7, 31);
                else
                    len_field = $urandom_range(1, 6);
                eff  = (len_field == 0) ? 1 : (len_field > MAX_BYTES ? MAX_BYTES : len_field);
                take = eff;
                if (eff > 1 && $urandom_range(0, 9) == 0)
                    take = $urandom_range(1, eff - 1);
                send_block(24'($urandom), 6'(len_field), take);
                // abandon the record part way through
                if (take < eff)
                begin
                    send_item(1'b1, 24'($urandom), 6'($urandom), 8'($urandom));
                    random_sent++;
                end
            end
        end
        @(negedge clk);
        item_valid <= 1'b0;

        drain();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** hex_record_framer_crc16: PASSED **");
        else
            $display("** hex_record_framer_crc16: FAILED **");
        $finish;
    end

endmodule

FILE: hex_record_framer_crc16.f
+incdir+rtl
rtl/hrf_pkg.sv
rtl/hrf_text.sv
rtl/hex_record_framer_crc16.sv
tb/hrf_checker.sv
tb/tb_top.sv
